/* sv/mts_pkg.sv */
// Shared types, constants and helpers for the multilevel feedback queue scheduler.
// No dependencies.
package mts_pkg;

  localparam int LEVELS      = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int THREADS     = 16;

  localparam int LW  = $clog2(LEVELS);
  localparam int TW  = $clog2(THREADS);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int QW  = 10;

  localparam logic [7:0] BASE_RESET = 8'd10;
  localparam logic [5:0] STEP_RESET = 6'd20;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_IDLE    = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_SUSPEND = 3'd4,
    CMD_RESUME  = 3'd5,
    CMD_CHOOSE  = 3'd6
  } cmd_t;

  typedef enum logic [0:0] {
    REG_BASE = 1'b0,
    REG_STEP = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_PLACE,
    ST_TICK,
    ST_SEL,
    ST_DONE
  } state_t;

  function automatic logic [QW-1:0] level_quantum(input logic [7:0] b, input logic [5:0] s,
                                                  input logic [LW-1:0] lv);
    return QW'(b) + QW'(s) * QW'(lv);
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [LW-1:0] lv, input logic [CW-1:0] idx);
    return QAW'(int'(lv) * QUEUE_DEPTH + int'(idx));
  endfunction

endpackage

/* sv/mts_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/mlfq_thread_scheduler.sv */
// Multilevel feedback queue scheduler top level: control sequencer, queue and quantum RAMs.
// Depends on mts_pkg and mts_ram.
//
// One command word is taken at a time and yields one result word. Per-level FIFOs live in one
// queue RAM, remaining/reload quanta in a second RAM; level, pinned, yield and scheduled bits
// are flops. Removing a thread from its queue, and popping the head of a level, sweep that
// level's entries through the queue RAM, each entry read, then written back if it is kept.
// A finished result sits in the output register while the next command word is accepted.
module mlfq_thread_scheduler import mts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [3:0] in_thread_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic       out_next_valid,
  output logic [3:0] out_next_thread,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [7:0]        base_r;
  logic [5:0]        step_r;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [TW-1:0]     tid_r, tid_nxt;
  logic              ok_r, ok_nxt;
  logic              run_valid_r, run_valid_nxt;
  logic [TW-1:0]     run_r, run_nxt;
  logic [CW-1:0]     counts_r [LEVELS];
  logic [CW-1:0]     counts_nxt [LEVELS];
  logic [LW-1:0]     level_r [THREADS];
  logic [LW-1:0]     level_nxt [THREADS];
  logic [THREADS-1:0] sched_r, sched_nxt, pin_r, pin_nxt, yield_r, yield_nxt;
  logic [LW-1:0]     scan_lv_r, scan_lv_nxt;
  logic [CW-1:0]     scan_rd_r, scan_rd_nxt, scan_wr_r, scan_wr_nxt;
  logic              scan_pop_r, scan_pop_nxt;
  logic [TW-1:0]     scan_tid_r, scan_tid_nxt;
  logic              out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic              out_nv_r, out_nv_nxt;
  logic [3:0]        out_nt_r, out_nt_nxt;

  logic              qwe;
  logic [QAW-1:0]    qwaddr, qraddr;
  logic [TW-1:0]     qwdata, qrdata;
  logic              rwe;
  logic [TW-1:0]     rwaddr;
  logic [2*QW-1:0]   rwdata, rrdata;

  logic              sel_found;
  logic [LW-1:0]     sel_lv;
  logic [TW-1:0]     t_in;
  logic              tid_ok;

  mts_ram #(.WIDTH(TW), .DEPTH(LEVELS * QUEUE_DEPTH)) u_qram (
    .clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata), .raddr(qraddr), .rdata(qrdata)
  );

  mts_ram #(.WIDTH(2 * QW), .DEPTH(THREADS)) u_rram (
    .clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata), .raddr(run_r), .rdata(rrdata)
  );

  assign t_in   = TW'(in_thread_id);
  assign tid_ok = 32'(in_thread_id) < THREADS;

  // lowest-numbered non-empty level
  always_comb begin
    sel_found = 1'b0;
    sel_lv    = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (counts_r[i] != '0) begin
        sel_found = 1'b1;
        sel_lv    = LW'(i);
      end
    end
  end

  always_comb begin
    logic              push_en;
    logic [LW-1:0]     push_lv;
    logic [TW-1:0]     push_tid;
    logic [LW-1:0]     cur_lv, new_lv;
    logic [QW-1:0]     lq, q_left, q_reload;
    logic              keep;
    logic              run_sched;
    logic [LW-1:0]     run_lv;

    push_en  = 1'b0;
    push_lv  = '0;
    push_tid = '0;
    cur_lv   = '0;
    new_lv   = '0;
    lq       = '0;
    q_left   = rrdata[QW-1:0];
    q_reload = rrdata[2*QW-1:QW];
    keep     = 1'b0;
    run_sched = 1'b0;
    run_lv   = '0;

    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    tid_nxt       = tid_r;
    ok_nxt        = ok_r;
    run_valid_nxt = run_valid_r;
    run_nxt       = run_r;
    counts_nxt    = counts_r;
    level_nxt     = level_r;
    sched_nxt     = sched_r;
    pin_nxt       = pin_r;
    yield_nxt     = yield_r;
    scan_lv_nxt   = scan_lv_r;
    scan_rd_nxt   = scan_rd_r;
    scan_wr_nxt   = scan_wr_r;
    scan_pop_nxt  = scan_pop_r;
    scan_tid_nxt  = scan_tid_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_ok_nxt    = out_ok_r;
    out_nv_nxt    = out_nv_r;
    out_nt_nxt    = out_nt_r;

    qwe    = 1'b0;
    qwaddr = '0;
    qwdata = '0;
    qraddr = qaddr(scan_lv_r, scan_rd_r);
    rwe    = 1'b0;
    rwaddr = tid_r;
    rwdata = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          tid_nxt      = t_in;
          ok_nxt       = 1'b0;
          scan_rd_nxt  = '0;
          scan_wr_nxt  = '0;
          scan_pop_nxt = 1'b0;
          scan_tid_nxt = t_in;
          scan_lv_nxt  = level_r[t_in];
          state_nxt    = ST_DONE;
          case (cmd_t'(in_cmd))
            CMD_ADD, CMD_IDLE: begin
              if (tid_ok) begin
                ret_nxt   = ST_PLACE;
                state_nxt = sched_r[t_in] ? ST_SCAN_RD : ST_PLACE;
              end
            end
            CMD_REMOVE, CMD_SUSPEND, CMD_RESUME: begin
              if (tid_ok && sched_r[t_in]) begin
                ok_nxt    = 1'b1;
                ret_nxt   = (cmd_t'(in_cmd) == CMD_RESUME) ? ST_PLACE : ST_DONE;
                state_nxt = ST_SCAN_RD;
                if (cmd_t'(in_cmd) == CMD_REMOVE) begin
                  sched_nxt[t_in] = 1'b0;
                end
              end
            end
            CMD_TICK: begin
              if (run_valid_r && sched_r[run_r]) begin
                state_nxt = ST_TICK;
              end
            end
            CMD_CHOOSE: state_nxt = ST_SEL;
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SCAN_RD: begin
        if (scan_rd_r == counts_r[scan_lv_r]) begin
          counts_nxt[scan_lv_r] = scan_wr_r;
          state_nxt             = ret_r;
        end else begin
          state_nxt = ST_SCAN_WR;
        end
      end

      ST_SCAN_WR: begin
        // pop drops the head word, drop compacts out every copy of the thread
        keep = scan_pop_r ? (scan_rd_r != '0) : (qrdata != scan_tid_r);
        if (keep) begin
          qwe         = 1'b1;
          qwaddr      = qaddr(scan_lv_r, scan_wr_r);
          qwdata      = qrdata;
          scan_wr_nxt = scan_wr_r + 1'b1;
        end
        if (scan_pop_r && scan_rd_r == '0) begin
          run_nxt       = qrdata;
          run_valid_nxt = 1'b1;
        end
        scan_rd_nxt = scan_rd_r + 1'b1;
        state_nxt   = ST_SCAN_RD;
      end

      ST_PLACE: begin
        cur_lv = level_r[tid_r];
        case (cmd_t'(cmd_r))
          CMD_ADD:  new_lv = '0;
          CMD_IDLE: new_lv = LW'(LEVELS - 1);
          default:  new_lv = (pin_r[tid_r] || cur_lv == '0) ? cur_lv : cur_lv - 1'b1;
        endcase
        lq                = level_quantum(base_r, step_r, new_lv);
        rwe               = 1'b1;
        rwaddr            = tid_r;
        rwdata            = {lq, lq};
        level_nxt[tid_r]  = new_lv;
        sched_nxt[tid_r]  = 1'b1;
        if (cmd_t'(cmd_r) == CMD_RESUME) begin
          run_sched = (run_r == tid_r) ? 1'b1 : sched_r[run_r];
          run_lv    = (run_r == tid_r) ? new_lv : level_r[run_r];
          if (run_valid_r && run_sched && run_lv > new_lv) begin
            yield_nxt[run_r] = 1'b1;
          end
        end else begin
          pin_nxt[tid_r]   = (cmd_t'(cmd_r) == CMD_IDLE);
          yield_nxt[tid_r] = 1'b0;
          if (cmd_t'(cmd_r) == CMD_ADD && run_valid_r) begin
            yield_nxt[run_r] = 1'b1;
          end
        end
        push_en   = 1'b1;
        push_lv   = new_lv;
        push_tid  = tid_r;
        state_nxt = ST_DONE;
      end

      ST_TICK: begin
        cur_lv = level_r[run_r];
        rwaddr = run_r;
        rwe    = 1'b1;
        if (yield_r[run_r]) begin
          rwdata           = {q_reload, q_reload};
          yield_nxt[run_r] = 1'b0;
          push_en          = 1'b1;
          push_lv          = cur_lv;
          push_tid         = run_r;
          state_nxt        = ST_SEL;
        end else if (q_left <= QW'(1)) begin
          new_lv = (!pin_r[run_r] && 32'(cur_lv) < LEVELS - 1) ? cur_lv + 1'b1 : cur_lv;
          lq               = level_quantum(base_r, step_r, new_lv);
          rwdata           = {lq, lq};
          level_nxt[run_r] = new_lv;
          push_en          = 1'b1;
          push_lv          = new_lv;
          push_tid         = run_r;
          state_nxt        = ST_SEL;
        end else begin
          rwdata    = {q_reload, q_left - 1'b1};
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_SEL: begin
        scan_lv_nxt  = sel_lv;
        scan_rd_nxt  = '0;
        scan_wr_nxt  = '0;
        scan_pop_nxt = 1'b1;
        ret_nxt      = ST_DONE;
        if (cmd_t'(cmd_r) == CMD_CHOOSE) begin
          ok_nxt = sel_found;
        end
        if (sel_found) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          run_valid_nxt = 1'b0;
          state_nxt     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_nv_nxt    = run_valid_r;
          out_nt_nxt    = run_valid_r ? 4'(run_r) : 4'd0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (push_en) begin
      if (counts_r[push_lv] < CW'(QUEUE_DEPTH)) begin
        qwe                 = 1'b1;
        qwaddr              = qaddr(push_lv, counts_r[push_lv]);
        qwdata              = push_tid;
        counts_nxt[push_lv] = counts_r[push_lv] + 1'b1;
        ok_nxt              = 1'b1;
      end else begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_DONE;
      run_valid_r <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      sched_r     <= '0;
      pin_r       <= '0;
      yield_r     <= '0;
      base_r      <= BASE_RESET;
      step_r      <= STEP_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        counts_r[i] <= '0;
      end
      for (int i = 0; i < THREADS; i++) begin
        level_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      run_valid_r <= run_valid_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      sched_r     <= sched_nxt;
      pin_r       <= pin_nxt;
      yield_r     <= yield_nxt;
      counts_r    <= counts_nxt;
      level_r     <= level_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE: base_r <= cfg_data;
          REG_STEP: step_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    tid_r      <= tid_nxt;
    ok_r       <= ok_nxt;
    scan_lv_r  <= scan_lv_nxt;
    scan_rd_r  <= scan_rd_nxt;
    scan_wr_r  <= scan_wr_nxt;
    scan_pop_r <= scan_pop_nxt;
    scan_tid_r <= scan_tid_nxt;
    out_ok_r   <= out_ok_nxt;
    out_nv_r   <= out_nv_nxt;
    out_nt_r   <= out_nt_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_next_valid  = out_nv_r;
  assign out_next_thread = out_nt_r;

endmodule

/* sv/mts_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
// Depends only on the top level's ports.
module mts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_ok,
  input logic       out_next_valid,
  input logic [3:0] out_next_thread
);

  // a held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> out_next_thread == 4'd0)
    else $error("next_thread not zero with nothing running");

  // one command word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted back to back");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

endmodule

bind mlfq_thread_scheduler mts_checker u_mts_checker (.*);

/* verif/mlfq_thread_scheduler_tb.sv */
// Self-checking testbench for mlfq_thread_scheduler: directed table, then random command words.
// Depends on mts_pkg and the scheduler RTL; scheduler behavior is predicted in-bench.
`timescale 1ns / 100ps

module mlfq_thread_scheduler_tb;
  import mts_pkg::*;

  typedef struct packed {
    logic       ok;
    logic       nv;
    logic [3:0] nt;
  } sched_res_t;

  typedef struct {
    cmd_t       cmd;
    logic [3:0] tid;
    bit         has_exp;
    sched_res_t exp_res;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [2:0] in_cmd = '0;
  logic [3:0] in_thread_id = '0;
  logic out_stall = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_stall, out_valid, out_ok, out_next_valid;
  logic [3:0] out_next_thread;

  mlfq_thread_scheduler dut (.*);

  // predictor state
  logic [3:0]    fifo [LEVELS][$];
  logic [LW-1:0] lvl_of [THREADS];
  bit            sched [THREADS];
  logic [QW-1:0] qleft [THREADS];
  logic [QW-1:0] qreload [THREADS];
  bit            pinned [THREADS];
  bit            yreq [THREADS];
  bit            run_v;
  logic [3:0]    run_t;
  logic [7:0]    base_q;
  logic [5:0]    step_q;

  sched_res_t pending_res [$];
  int  fails = 0;
  int  cycles = 0;
  bit  stim_done = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [QW-1:0] quantum_at(int lv);
    return QW'(base_q) + QW'(step_q) * QW'(lv);
  endfunction

  function automatic void drop_entry(int lv, logic [3:0] t);
    for (int i = fifo[lv].size() - 1; i >= 0; i--)
      if (fifo[lv][i] == t) fifo[lv].delete(i);
  endfunction

  function automatic bit push_entry(int lv, logic [3:0] t);
    if (fifo[lv].size() >= QUEUE_DEPTH) return 0;
    fifo[lv].push_back(t);
    return 1;
  endfunction

  function automatic void pick_next();
    run_v = 0;
    for (int lv = 0; lv < LEVELS; lv++)
      if (fifo[lv].size() > 0) begin
        run_t = fifo[lv].pop_front();
        run_v = 1;
        return;
      end
  endfunction

  function automatic bit place_thread(logic [3:0] t, int lv, bit pin);
    if (sched[t]) drop_entry(lvl_of[t], t);
    sched[t] = 1;
    lvl_of[t] = LW'(lv);
    qleft[t] = quantum_at(lv);
    qreload[t] = qleft[t];
    pinned[t] = pin;
    yreq[t] = 0;
    return push_entry(lv, t);
  endfunction

  function automatic sched_res_t predict_event(cmd_t c, logic [3:0] t);
    sched_res_t r;
    bit ok;
    int lv;
    bit spent;
    logic [3:0] rt;
    ok = 0;
    case (c)
      CMD_ADD: begin
        ok = place_thread(t, 0, 0);
        if (run_v) yreq[run_t] = 1;
      end
      CMD_REMOVE, CMD_SUSPEND: if (sched[t]) begin
        drop_entry(lvl_of[t], t);
        if (c == CMD_REMOVE) sched[t] = 0;
        ok = 1;
      end
      CMD_IDLE: ok = place_thread(t, LEVELS - 1, 1);
      CMD_TICK: if (run_v && sched[run_t]) begin
        rt = run_t;
        lv = lvl_of[rt];
        spent = qleft[rt] <= 1;
        qleft[rt] = (qleft[rt] != 0) ? QW'(qleft[rt] - 1) : '0;
        if (yreq[rt]) begin
          qleft[rt] = qreload[rt];
          yreq[rt] = 0;
          ok = push_entry(lv, rt);
          pick_next();
        end else if (spent) begin
          if (!pinned[rt] && lv < LEVELS - 1) lv++;
          lvl_of[rt] = LW'(lv);
          qleft[rt] = quantum_at(lv);
          qreload[rt] = qleft[rt];
          ok = push_entry(lv, rt);
          pick_next();
        end else begin
          ok = 1;
        end
      end
      CMD_RESUME: if (sched[t]) begin
        lv = lvl_of[t];
        drop_entry(lv, t);
        if (!pinned[t] && lv > 0) lv--;
        lvl_of[t] = LW'(lv);
        qleft[t] = quantum_at(lv);
        qreload[t] = qleft[t];
        if (run_v && sched[run_t] && lvl_of[run_t] > lv) yreq[run_t] = 1;
        ok = push_entry(lv, t);
      end
      CMD_CHOOSE: begin
        pick_next();
        ok = run_v;
      end
      default: ok = 0;
    endcase
    r.ok = ok;
    r.nv = run_v;
    r.nt = run_v ? run_t : 4'd0;
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_BASE) base_q = val;
    else step_q = val[5:0];
  endtask

  // c is logic so the unused code 7 can be sent
  task automatic send_word(logic [2:0] c, logic [3:0] t, bit has_exp, sched_res_t ex);
    sched_res_t p;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    // with no gap the next word follows the accepted one directly
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_thread_id <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_event(cmd_t'(c), t);
    if (has_exp && p != ex) begin
      $error("table row disagrees with prediction: exp %h pred %h", ex, p);
      fails++;
    end
    pending_res.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_res.size() > 0) @(posedge clk);
    repeat (2 * QUEUE_DEPTH + 10) @(posedge clk);
  endtask

  // receiver: random stall per word
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_res.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          sched_res_t e;
          e = pending_res.pop_front();
          if (out_ok !== e.ok) begin
            $error("ok exp %0d got %0d", e.ok, out_ok); fails++;
          end
          if (out_next_valid !== e.nv) begin
            $error("next_valid exp %0d got %0d", e.nv, out_next_valid); fails++;
          end
          if (out_next_thread !== e.nt) begin
            $error("next_thread exp %0d got %0d", e.nt, out_next_thread); fails++;
          end
        end
        hold = (stim_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        out_stall <= hold != 0;
      end else if (out_stall) begin
        if (hold > 0) hold--;
        if (hold == 0) out_stall <= 0;
      end
    end
  end

  stim_row_t rows [$];

  function automatic void add_row(cmd_t c, logic [3:0] t, bit he, sched_res_t e);
    stim_row_t s;
    s.cmd = c; s.tid = t; s.has_exp = he; s.exp_res = e;
    rows.push_back(s);
  endfunction

  initial begin
    int n;
    int k;
    logic [2:0] c;
    logic [3:0] t;
    for (int i = 0; i < THREADS; i++) begin
      sched[i] = 0; pinned[i] = 0; yreq[i] = 0; lvl_of[i] = 0; qleft[i] = 0; qreload[i] = 0;
    end
    run_v = 0; run_t = 0;
    base_q = BASE_RESET; step_q = STEP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // after reset: nothing scheduled
    add_row(CMD_TICK, 4'd0, 1, '{ok: 0, nv: 0, nt: 0});
    add_row(CMD_CHOOSE, 4'd0, 1, '{ok: 0, nv: 0, nt: 0});
    add_row(CMD_REMOVE, 4'd15, 1, '{ok: 0, nv: 0, nt: 0});
    add_row(CMD_SUSPEND, 4'd3, 1, '{ok: 0, nv: 0, nt: 0});
    add_row(CMD_RESUME, 4'd3, 1, '{ok: 0, nv: 0, nt: 0});
    add_row(CMD_ADD, 4'd15, 1, '{ok: 1, nv: 0, nt: 0});
    add_row(CMD_ADD, 4'd0, 1, '{ok: 1, nv: 0, nt: 0});
    add_row(CMD_ADD, 4'd0, 1, '{ok: 1, nv: 0, nt: 0});  // re-add, no double entry
    add_row(CMD_IDLE, 4'd7, 1, '{ok: 1, nv: 0, nt: 0});
    add_row(CMD_CHOOSE, 4'd0, 1, '{ok: 1, nv: 1, nt: 15});
    add_row(CMD_TICK, 4'd0, 0, '0);
    add_row(CMD_ADD, 4'd5, 0, '0);
    add_row(CMD_TICK, 4'd0, 0, '0);  // yield
    add_row(CMD_SUSPEND, 4'd0, 0, '0);
    add_row(CMD_RESUME, 4'd0, 0, '0);
    add_row(CMD_RESUME, 4'd7, 0, '0);  // pinned stays
    add_row(CMD_REMOVE, 4'd5, 0, '0);
    add_row(CMD_CHOOSE, 4'd0, 0, '0);
    for (int i = 0; i < rows.size(); i++)
      send_word(rows[i].cmd, rows[i].tid, rows[i].has_exp, rows[i].exp_res);
    // unused opcode
    send_word(3'd7, 4'd9, 1, '{ok: 0, nv: run_v, nt: run_v ? run_t : 4'd0});

    // saturate level 0: all threads added, then run ticks at quantum 1
    drain();
    reg_write(REG_BASE, 8'd1);
    reg_write(REG_STEP, 8'd0);
    for (int i = 0; i < THREADS; i++) send_word(CMD_ADD, i[3:0], 0, '0);
    send_word(CMD_CHOOSE, 4'd0, 0, '0);
    for (int i = 0; i < 20; i++) send_word(CMD_TICK, 4'd0, 0, '0);

    // random phases with config settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin reg_write(REG_BASE, 8'd255); reg_write(REG_STEP, 8'd63); end
        1: begin reg_write(REG_BASE, 8'd1); reg_write(REG_STEP, 8'd0); end
        2: begin reg_write(REG_BASE, 8'd2); reg_write(REG_STEP, 8'd1); end
        3: begin reg_write(REG_BASE, 8'd0); reg_write(REG_STEP, 8'd3); end
        default: begin
          reg_write(REG_BASE, 8'($urandom_range(1, 8)));
          reg_write(REG_STEP, 8'($urandom_range(0, 63)));
        end
      endcase
      n = 255;
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 99);
        t = 4'($urandom_range(0, 15));
        if (k < 40) c = CMD_TICK;
        else if (k < 55) c = CMD_ADD;
        else if (k < 63) c = CMD_CHOOSE;
        else if (k < 71) c = CMD_RESUME;
        else if (k < 79) c = CMD_SUSPEND;
        else if (k < 86) c = CMD_REMOVE;
        else if (k < 96) c = CMD_IDLE;
        else c = 3'($urandom_range(0, 7));
        send_word(c, t, 0, '0);
      end
    end

    stim_done = 1;
    drain();
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

/* sim.f */
sv/mts_pkg.sv
sv/mts_ram.sv
sv/mlfq_thread_scheduler.sv
sv/mts_checker.sv
verif/mlfq_thread_scheduler_tb.sv
